@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset
`define BRA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequent holds in the cycle of its antecedent
`define BRA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define BRA_ASSERT(lbl, clk, rst, prop, msg)
`define BRA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded rational approximation package
// Field widths, reset constants, state encodings and the divider status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bra_pkg;

   // Fixed field widths
   localparam int RATIO_W = 32;
   localparam int LIM_W   = 17;

   // Reset value of the limit register
   localparam logic [LIM_W-1:0] MAX_DEN_RESET = 17'd65536;

   // Main sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_WAIT,
      ST_CHK_Q,
      ST_UPD,
      ST_SEMI,
      ST_K_WAIT,
      ST_SQ,
      ST_T1,
      ST_T2,
      ST_T3,
      ST_T4,
      ST_H,
      ST_G,
      ST_CMP,
      ST_DONE
   } bra_state_type;

   // Divider states
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_ALIGN,
      DIV_SUB
   } div_state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ rtl/bra_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one Q16.16 ratio word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bra_req_if;
   logic                         valid;
   logic                         ready;
   logic [bra_pkg::RATIO_W-1:0]  ratio_q16;

   modport source (output valid, output ratio_q16, input ready);
   modport sink   (input valid, input ratio_q16, output ready);
endinterface

@@ rtl/bra_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one fraction result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bra_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [bra_pkg::LIM_W-1:0]  numerator;
   logic [bra_pkg::LIM_W-1:0]  denominator;

   modport source (output valid, output found, output numerator, output denominator,
                   input ready);
   modport sink   (input valid, input found, input numerator, input denominator,
                   output ready);
endinterface

@@ rtl/bra_div.sv @@
// ----------------------------------------------------------------------------
// Iterative divider
// Shift-align then restore, one compare/subtract per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_div #(
   parameter int W = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [W-1:0]          dividend,
   input  logic [W-1:0]          divisor,
   output bra_pkg::div_stat_type stat,
   output logic [W-1:0]          quot,
   output logic [W-1:0]          rem
);

   localparam int CW = $clog2(W);

   bra_pkg::div_state_type state_ff, state_in;
   logic [W-1:0]  dsh_ff, dsh_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quot_ff, quot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   // Shared compare: doubled divisor while aligning, divisor while subtracting
   logic [W:0] cmp_b;
   logic       ge;

   assign cmp_b = (state_ff == bra_pkg::DIV_ALIGN) ? {dsh_ff, 1'b0} : {1'b0, dsh_ff};
   assign ge    = ({1'b0, rem_ff} >= cmp_b);

   // Hold state and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bra_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dsh_ff  <= dsh_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   // Sequence align and subtract phases
   always_comb begin
      state_in = state_ff;
      dsh_in   = dsh_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         bra_pkg::DIV_IDLE: begin
            if (start) begin
               rem_in   = dividend;
               dsh_in   = divisor;
               quot_in  = '0;
               cnt_in   = '0;
               state_in = bra_pkg::DIV_ALIGN;
            end
         end
         bra_pkg::DIV_ALIGN: begin
            if (ge) begin
               dsh_in = {dsh_ff[W-2:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = bra_pkg::DIV_SUB;
            end
         end
         bra_pkg::DIV_SUB: begin
            if (ge) begin
               rem_in  = rem_ff - dsh_ff;
               quot_in = {quot_ff[W-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = bra_pkg::DIV_IDLE;
            end else begin
               dsh_in = {1'b0, dsh_ff[W-1:1]};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = bra_pkg::DIV_IDLE;
      endcase
   end

   assign stat.busy = (state_ff != bra_pkg::DIV_IDLE);
   assign stat.done = done_ff;
   assign quot      = quot_ff;
   assign rem       = rem_ff;

endmodule

@@ rtl/bra_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiply-accumulate
// Registered a * b + c; the result is ready in the cycle after the operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bra_mul #(
   parameter int AW = 50,
   parameter int BW = 17
) (
   input  logic              clock,
   input  logic [AW-1:0]     op_a,
   input  logic [BW-1:0]     op_b,
   input  logic [BW-1:0]     op_c,
   output logic [AW+BW-1:0]  prod
);

   localparam int MW = AW + BW;

   logic [MW-1:0] prod_ff, prod_in;

   // Form product plus addend
   assign prod_in = ({{BW{1'b0}}, op_a} * {{AW{1'b0}}, op_b}) + {{AW{1'b0}}, op_c};

   // Register the result
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ rtl/bounded_rational_approximation.sv @@
// ----------------------------------------------------------------------------
// Bounded rational approximation
// Best fraction p/q with p, q no larger than a programmable limit.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one unsigned fixed-point ratio word (FRAC_BITS fraction
//   bits) when valid and ready are high; ready is high only while the
//   sequencer is idle and out of reset, so one word is in work at a time.
//   rsp_chan returns exactly one word per request: found, numerator and
//   denominator. A zero ratio or a zero limit returns found = 0, zero parts.
//   csr_wr_en / csr_wr_data write the limit (reset 65536); write only while
//   no request is in work.
// Steps: each continued-fraction term costs one divide on the shared
//   shift/subtract divider plus two products on the shared multiplier; the
//   semiconvergent check adds one divide for k and the cross-multiplies.
//   The term count stays below 30 for a 17-bit limit. A zero ratio or a
//   zero limit skips the expansion and goes straight to the done state.
// Stall: a finished word waits in the response register; a new request may
//   be accepted meanwhile, and the next result holds until the slot is free.
// Reset: clears the sequencer, the response valid and restores the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_rational_approximation #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_TERMS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   bra_req_if.sink                   req_chan,
   bra_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [bra_pkg::LIM_W-1:0] csr_wr_data
);

   localparam int LW = bra_pkg::LIM_W;
   localparam int XW = ((FRAC_BITS > bra_pkg::RATIO_W) ? FRAC_BITS : bra_pkg::RATIO_W) + 1;
   localparam int PW = XW + LW;
   localparam int MW = PW + LW;
   localparam int TW = $clog2(MAX_TERMS + 1);
   localparam logic [XW-1:0] ONE = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;

   function automatic logic [PW-1:0] abs_diff(input logic [PW-1:0] x, input logic [PW-1:0] y);
      return (x >= y) ? (x - y) : (y - x);
   endfunction

   bra_pkg::bra_state_type state_ff, state_in;

   logic [LW-1:0] max_den_ff, max_den_in;
   logic [XW-1:0] xn_ff, xn_in, xd_ff, xd_in;
   logic [XW-1:0] num_ff, num_in, den_ff, den_in;
   logic [XW-1:0] a_ff, a_in, rem_ff, rem_in;
   logic [LW-1:0] p0_ff, p0_in, q0_ff, q0_in, p1_ff, p1_in, q1_ff, q1_in;
   logic [LW-1:0] q2_ff, q2_in, k_ff, k_in, sp_ff, sp_in, sq_ff, sq_in;
   logic [LW-1:0] bp_ff, bp_in, bq_ff, bq_in;
   logic [PW-1:0] t_ff, t_in, ds_ff, ds_in, dc_ff, dc_in;
   logic [MW-1:0] h_ff, h_in;
   logic [TW-1:0] term_ff, term_in;
   logic          invert_ff, invert_in, exact_ff, exact_in, fail_ff, fail_in;
   logic          out_valid_ff, out_valid_in, out_found_ff, out_found_in;
   logic [LW-1:0] out_num_ff, out_num_in, out_den_ff, out_den_in;

   // Shared unit hookups
   logic                  div_start;
   logic [XW-1:0]         div_n, div_d, div_q, div_r;
   bra_pkg::div_stat_type div_stat;
   logic [PW-1:0]         mul_a;
   logic [LW-1:0]         mul_b, mul_c;
   logic [MW-1:0]         mul_prod;

   // Final fix-ups
   logic [LW-1:0] fix_p, res_num, res_den;
   logic          res_ok;
   logic [XW-1:0] ratio_x;

   bra_div #(.W(XW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .stat     (div_stat),
      .quot     (div_q),
      .rem      (div_r)
   );

   bra_mul #(.AW(PW), .BW(LW)) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .op_c  (mul_c),
      .prod  (mul_prod)
   );

   assign ratio_x = {{(XW-bra_pkg::RATIO_W){1'b0}}, req_chan.ratio_q16};
   assign fix_p   = (bp_ff == '0) ? {{(LW-1){1'b0}}, 1'b1} : bp_ff;
   assign res_num = invert_ff ? bq_ff : fix_p;
   assign res_den = invert_ff ? fix_p : bq_ff;
   assign res_ok  = !fail_ff && (res_num <= max_den_ff) && (res_den <= max_den_ff);

   // Take limit writes
   assign max_den_in = csr_wr_en ? csr_wr_data : max_den_ff;

   // Hold control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bra_pkg::ST_IDLE;
         max_den_ff   <= bra_pkg::MAX_DEN_RESET;
         out_valid_ff <= 1'b0;
         term_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         max_den_ff   <= max_den_in;
         out_valid_ff <= out_valid_in;
         term_ff      <= term_in;
      end
      xn_ff <= xn_in;  xd_ff <= xd_in;
      num_ff <= num_in;  den_ff <= den_in;
      a_ff <= a_in;  rem_ff <= rem_in;
      p0_ff <= p0_in;  q0_ff <= q0_in;  p1_ff <= p1_in;  q1_ff <= q1_in;
      q2_ff <= q2_in;  k_ff <= k_in;  sp_ff <= sp_in;  sq_ff <= sq_in;
      bp_ff <= bp_in;  bq_ff <= bq_in;
      t_ff <= t_in;  ds_ff <= ds_in;  dc_ff <= dc_in;  h_ff <= h_in;
      invert_ff <= invert_in;  exact_ff <= exact_in;  fail_ff <= fail_in;
      out_found_ff <= out_found_in;  out_num_ff <= out_num_in;  out_den_ff <= out_den_in;
   end

   // Sequence the expansion over the shared divider and multiplier
   always_comb begin
      state_in     = state_ff;
      xn_in = xn_ff;  xd_in = xd_ff;  num_in = num_ff;  den_in = den_ff;
      a_in = a_ff;  rem_in = rem_ff;
      p0_in = p0_ff;  q0_in = q0_ff;  p1_in = p1_ff;  q1_in = q1_ff;
      q2_in = q2_ff;  k_in = k_ff;  sp_in = sp_ff;  sq_in = sq_ff;
      bp_in = bp_ff;  bq_in = bq_ff;
      t_in = t_ff;  ds_in = ds_ff;  dc_in = dc_ff;  h_in = h_ff;
      term_in = term_ff;
      invert_in = invert_ff;  exact_in = exact_ff;  fail_in = fail_ff;
      out_found_in = out_found_ff;  out_num_in = out_num_ff;  out_den_in = out_den_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      div_start = 1'b0;
      div_n     = num_ff;
      div_d     = den_ff;
      mul_a     = '0;
      mul_b     = '0;
      mul_c     = '0;
      req_chan.ready = (state_ff == bra_pkg::ST_IDLE) && !reset;

      unique case (state_ff)
         bra_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               invert_in = (ratio_x > ONE);
               xn_in     = (ratio_x > ONE) ? ONE : ratio_x;
               xd_in     = (ratio_x > ONE) ? ratio_x : ONE;
               num_in    = (ratio_x > ONE) ? ONE : ratio_x;
               den_in    = (ratio_x > ONE) ? ratio_x : ONE;
               p0_in = '0;  q0_in = {{(LW-1){1'b0}}, 1'b1};
               p1_in = {{(LW-1){1'b0}}, 1'b1};  q1_in = '0;
               bp_in = '0;  bq_in = '0;
               term_in  = '0;
               exact_in = 1'b0;
               fail_in  = (req_chan.ratio_q16 == '0) || (max_den_ff == '0);
               state_in = ((req_chan.ratio_q16 == '0) || (max_den_ff == '0)) ?
                          bra_pkg::ST_DONE : bra_pkg::ST_DIV;
            end
         end
         // Start one Euclid step
         bra_pkg::ST_DIV: begin
            div_start = 1'b1;
            state_in  = bra_pkg::ST_DIV_WAIT;
         end
         // Take the partial quotient and form the next denominator
         bra_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               a_in     = div_q;
               rem_in   = div_r;
               mul_a    = {{LW{1'b0}}, div_q};
               mul_b    = q1_ff;
               mul_c    = q0_ff;
               state_in = bra_pkg::ST_CHK_Q;
            end
         end
         // Stop on a denominator over the limit, else form the numerator
         bra_pkg::ST_CHK_Q: begin
            if (mul_prod > {{(MW-LW){1'b0}}, max_den_ff}) begin
               state_in = bra_pkg::ST_SEMI;
            end else begin
               q2_in    = mul_prod[LW-1:0];
               mul_a    = {{LW{1'b0}}, a_ff};
               mul_b    = p1_ff;
               mul_c    = p0_ff;
               state_in = bra_pkg::ST_UPD;
            end
         end
         // Advance the convergents
         bra_pkg::ST_UPD: begin
            p0_in = p1_ff;
            q0_in = q1_ff;
            p1_in = mul_prod[LW-1:0];
            q1_in = q2_ff;
            if (rem_ff == '0) begin
               exact_in = 1'b1;
               state_in = bra_pkg::ST_SEMI;
            end else begin
               num_in  = den_ff;
               den_in  = rem_ff;
               term_in = term_ff + 1'b1;
               state_in = (term_ff == TW'(MAX_TERMS - 1)) ? bra_pkg::ST_SEMI : bra_pkg::ST_DIV;
            end
         end
         // Keep the convergent and try the largest semiconvergent
         bra_pkg::ST_SEMI: begin
            bp_in = p1_ff;
            bq_in = (q1_ff != '0) ? q1_ff : {{(LW-1){1'b0}}, 1'b1};
            if (!exact_ff && (q1_ff != '0) && (max_den_ff >= q0_ff)) begin
               div_start = 1'b1;
               div_n     = {{(XW-LW){1'b0}}, max_den_ff - q0_ff};
               div_d     = {{(XW-LW){1'b0}}, q1_ff};
               state_in  = bra_pkg::ST_K_WAIT;
            end else begin
               state_in = bra_pkg::ST_DONE;
            end
         end
         bra_pkg::ST_K_WAIT: begin
            if (div_stat.done) begin
               if (div_q == '0) begin
                  state_in = bra_pkg::ST_DONE;
               end else begin
                  k_in     = div_q[LW-1:0];
                  mul_a    = {{(PW-LW){1'b0}}, div_q[LW-1:0]};
                  mul_b    = p1_ff;
                  mul_c    = p0_ff;
                  state_in = bra_pkg::ST_SQ;
               end
            end
         end
         bra_pkg::ST_SQ: begin
            sp_in    = mul_prod[LW-1:0];
            mul_a    = {{(PW-LW){1'b0}}, k_ff};
            mul_b    = q1_ff;
            mul_c    = q0_ff;
            state_in = bra_pkg::ST_T1;
         end
         // Cross-multiply both candidates against the ratio
         bra_pkg::ST_T1: begin
            if ((mul_prod > {{(MW-LW){1'b0}}, max_den_ff}) || (mul_prod == '0)) begin
               state_in = bra_pkg::ST_DONE;
            end else begin
               sq_in    = mul_prod[LW-1:0];
               mul_a    = {{LW{1'b0}}, xd_ff};
               mul_b    = sp_ff;
               state_in = bra_pkg::ST_T2;
            end
         end
         bra_pkg::ST_T2: begin
            t_in     = mul_prod[PW-1:0];
            mul_a    = {{LW{1'b0}}, xn_ff};
            mul_b    = sq_ff;
            state_in = bra_pkg::ST_T3;
         end
         bra_pkg::ST_T3: begin
            ds_in    = abs_diff(t_ff, mul_prod[PW-1:0]);
            mul_a    = {{LW{1'b0}}, xd_ff};
            mul_b    = p1_ff;
            state_in = bra_pkg::ST_T4;
         end
         bra_pkg::ST_T4: begin
            t_in     = mul_prod[PW-1:0];
            mul_a    = {{LW{1'b0}}, xn_ff};
            mul_b    = q1_ff;
            state_in = bra_pkg::ST_H;
         end
         bra_pkg::ST_H: begin
            dc_in    = abs_diff(t_ff, mul_prod[PW-1:0]);
            mul_a    = ds_ff;
            mul_b    = q1_ff;
            state_in = bra_pkg::ST_G;
         end
         bra_pkg::ST_G: begin
            h_in     = mul_prod;
            mul_a    = dc_ff;
            mul_b    = sq_ff;
            state_in = bra_pkg::ST_CMP;
         end
         // Prefer the semiconvergent on a tie
         bra_pkg::ST_CMP: begin
            if (h_ff <= mul_prod) begin
               bp_in = sp_ff;
               bq_in = sq_ff;
            end
            state_in = bra_pkg::ST_DONE;
         end
         // Load the response register once it is free
         bra_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_found_in = res_ok;
               out_num_in   = res_ok ? res_num : '0;
               out_den_in   = res_ok ? res_den : '0;
               state_in     = bra_pkg::ST_IDLE;
            end
         end
         default: state_in = bra_pkg::ST_IDLE;
      endcase
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.found       = out_found_ff;
   assign rsp_chan.numerator   = out_num_ff;
   assign rsp_chan.denominator = out_den_ff;

   `BRA_ASSERT(a_q1_in_limit, clock, reset, (state_ff == bra_pkg::ST_IDLE) || (q1_ff <= max_den_ff), "convergent denominator over limit")
   `BRA_ASSERT_IMP(a_found_parts, clock, reset, rsp_chan.valid && rsp_chan.found, (rsp_chan.numerator != '0) && (rsp_chan.denominator != '0), "found word with a zero part")
   `BRA_ASSERT_IMP(a_miss_zero, clock, reset, rsp_chan.valid && !rsp_chan.found, (rsp_chan.numerator == '0) && (rsp_chan.denominator == '0), "not-found word with nonzero parts")
   `BRA_ASSERT_IMP(a_div_start_idle, clock, reset, div_start, !div_stat.busy, "divider started while busy")
   `BRA_ASSERT(a_term_bound, clock, reset, term_ff <= TW'(MAX_TERMS), "term count past bound")

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Bounded rational approximation testbench
// Sends Q16.16 ratio words under random idling and a long response hold-off,
// predicts the best bounded fraction p/q for each accepted word with exact
// integer continued-fraction steps, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAC_BITS  = 16;
   localparam int MAX_TERMS  = 64;
   localparam int STALL_MAX  = 5000;
   localparam int DRAIN_WAIT = 600;
   localparam int HOLD_LEN   = 400;
   localparam int HOLD_AT    = 900;
   localparam int CALM_LO    = 500;
   localparam int CALM_HI    = 700;

   typedef logic [bra_pkg::RATIO_W-1:0] ratio_type;
   typedef logic [bra_pkg::LIM_W-1:0]   part_type;

   typedef struct packed {
      logic     found;
      part_type numerator;
      part_type denominator;
   } fraction_type;

   // Hold the limit copy and the fractions still owed by the block
   class fraction_board_type;
      fraction_type expected_q[$];
      part_type     limit;
      int           errors;
      int           checked;

      function new();
         limit   = bra_pkg::MAX_DEN_RESET;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_limit(input part_type value);
         limit = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Best fraction with both parts no larger than the limit
      function fraction_type best_fraction(input ratio_type ratio, input part_type bound);
         longint unsigned lim, unity, xn, xd, num, den, quo, rem;
         longint unsigned p0, q0, p1, q1, p2, q2, bp, bq, k, sp, sq, ds, dc, t;
         logic [127:0] semi_err, conv_err;
         bit flip, exact;
         int i;
         fraction_type res;
         res = '0;
         lim = 64'(bound);
         unity = 64'd1 << FRAC_BITS;
         if (ratio == 0 || lim == 0) return res;

         // Fold ratios above one into the unit interval
         flip = 64'(ratio) > unity;
         if (flip) begin
            xn = unity;
            xd = 64'(ratio);
         end else begin
            xn = 64'(ratio);
            xd = unity;
         end

         // Advance the expansion until the denominator would pass the limit
         num = xn;
         den = xd;
         p0 = 0; q0 = 1; p1 = 1; q1 = 0;
         exact = 1'b0;
         for (i = 0; i < MAX_TERMS; i++) begin
            quo = num / den;
            rem = num - quo * den;
            p2 = quo * p1 + p0;
            q2 = quo * q1 + q0;
            if (q2 > lim) break;
            p0 = p1; q0 = q1;
            p1 = p2; q1 = q2;
            if (rem == 0) begin
               exact = 1'b1;
               break;
            end
            num = den;
            den = rem;
         end

         // Try the largest admissible semiconvergent; a tie goes to it
         bp = p1;
         bq = (q1 > 0) ? q1 : 1;
         if (!exact && q1 > 0 && lim >= q0) begin
            k = (lim - q0) / q1;
            if (k > 0) begin
               sp = p0 + k * p1;
               sq = q0 + k * q1;
               if (sq <= lim && sq > 0) begin
                  ds = (sp * xd >= xn * sq) ? sp * xd - xn * sq : xn * sq - sp * xd;
                  dc = (p1 * xd >= xn * q1) ? p1 * xd - xn * q1 : xn * q1 - p1 * xd;
                  semi_err = 128'(ds) * 128'(q1);
                  conv_err = 128'(dc) * 128'(sq);
                  if (semi_err <= conv_err) begin
                     bp = sp;
                     bq = sq;
                  end
               end
            end
         end

         if (bp == 0) bp = 1;
         if (flip) begin
            t  = bp;
            bp = bq;
            bq = t;
         end
         if (bp > lim || bq > lim) return res;
         res.found       = 1'b1;
         res.numerator   = bp[bra_pkg::LIM_W-1:0];
         res.denominator = bq[bra_pkg::LIM_W-1:0];
         return res;
      endfunction

      function void note_ratio(input ratio_type ratio);
         expected_q.insert(expected_q.size(), best_fraction(ratio, limit));
      endfunction

      task report_mismatch(input string what);
         $display("ERROR result %0d: %s", checked, what);
         errors++;
      endtask

      task check_fraction(input fraction_type got);
         fraction_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result word with no ratio pending");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
         if (got.numerator !== want.numerator)
            report_mismatch($sformatf("numerator %0d, expected %0d",
                                      got.numerator, want.numerator));
         if (got.denominator !== want.denominator)
            report_mismatch($sformatf("denominator %0d, expected %0d",
                                      got.denominator, want.denominator));
      endtask
   endclass

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   part_type csr_wr_data;
   int       sent;
   int       stall_cycles;

   bra_req_if req ();
   bra_rsp_if rsp ();

   fraction_board_type board = new();

   bounded_rational_approximation #(
      .FRAC_BITS(FRAC_BITS),
      .MAX_TERMS(MAX_TERMS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // Offer one ratio word, idling at random outside the calm window
   task automatic send_ratio(input ratio_type ratio);
      while (!(sent >= CALM_LO && sent < CALM_HI) && $urandom_range(99) < 28) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.ratio_q16 <= ratio;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_ratio(ratio);
      sent++;
   endtask

   // Drop valid and wait until every owed fraction has come back
   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Write the limit once the block is idle
   task automatic write_limit(input part_type value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      board.set_limit(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Accept result words; stall at random, hold off once for a long stretch
   initial begin : result_side
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready)
            board.check_fraction('{rsp.found, rsp.numerator, rsp.denominator});
         if (!held && board.checked == HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (board.checked >= CALM_LO && board.checked < CALM_HI) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(99) >= 28);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_MAX) begin
            $display("bounded_rational_approximation: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      ratio_type at_reset_ratios [14] = '{
         32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
         32'h0001_0001, 32'h0000_FFFF, 32'h0000_8000, 32'h0003_243F,
         32'h0000_5555, 32'hFFFF_0000, 32'h8000_0000, 32'h0002_0000,
         32'h0001_8000, 32'h0000_B505};
      ratio_type unit_ratios [4] = '{
         32'h0000_8000, 32'h0000_4000, 32'h0003_0000, 32'h0000_0001};
      ratio_type wide_ratios [3] = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_243F};
      ratio_type ratio;
      part_type limit;
      longint unsigned p, q;
      int n_items;
      int ph;

      clock         = 1'b0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req.valid     = 1'b0;
      req.ratio_q16 = '0;
      rsp.ready     = 1'b0;
      sent          = 0;
      stall_cycles  = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words: field extremes at the reset limit
      foreach (at_reset_ratios[j]) send_ratio(at_reset_ratios[j]);

      // Limit of one: half is a tie that picks the semiconvergent
      write_limit(17'd1);
      foreach (unit_ratios[j]) send_ratio(unit_ratios[j]);

      // Zero limit gives not-found
      write_limit(17'd0);
      send_ratio(32'h0001_2345);
      send_ratio(32'h0000_8000);

      // Limit above 65536
      write_limit(17'h1FFFF);
      foreach (wide_ratios[j]) send_ratio(wide_ratios[j]);

      write_limit(17'd2);
      send_ratio(32'h0000_5555);

      // Random words over a range of limits
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       limit = bra_pkg::MAX_DEN_RESET;
            1:       limit = 17'h1FFFF;
            2:       limit = part_type'($urandom_range(16, 1));
            3:       limit = part_type'($urandom_range(4096, 17));
            4:       limit = 17'd1;
            5:       limit = 17'd0;
            6:       limit = part_type'($urandom_range(131071, 4097));
            default: limit = part_type'($urandom_range(131071, 1));
         endcase
         n_items = (limit == 0) ? 20 : 170;
         write_limit(limit);
         repeat (n_items) begin
            case ($urandom_range(9))
               0, 1, 2: ratio = $urandom;
               3, 4:    ratio = {16'h0000, 16'($urandom)};
               5:       ratio = $urandom_range(32'h0001_0040, 32'h0000_FFC0);
               6: begin
                  p = $urandom_range(300, 1);
                  q = $urandom_range(300, 1);
                  ratio = ratio_type'((p << FRAC_BITS) / q);
               end
               7:       ratio = $urandom_range(16, 0);
               8:       ratio = $urandom | 32'h0100_0000;
               default: ratio = 32'h1 << $urandom_range(31);
            endcase
            send_ratio(ratio);
         end
      end

      // Let the last words come back, then settle
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("bounded_rational_approximation: match");
      end else begin
         $display("bounded_rational_approximation: mismatch");
      end
      $finish;
   end

endmodule
